// File: hw/rtl/thd_pkg.sv
// shared types and constants of the tumbler humber decoder
package thd_pkg;

   localparam int MAX_DIGITS = 16;
   localparam int DC_W       = $clog2(MAX_DIGITS + 1);

   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 2;
   localparam int INDEX_W = 4;
   localparam int VALUE_W = 32;
   localparam int HBL_W   = 3;
   localparam int PBS_W   = 3;

   localparam logic [KIND_W-1:0] KIND_EXP   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DIGIT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

   localparam logic [BYTE_W-1:0] SHORT_LIMIT = 8'd128;
   localparam logic [BYTE_W-1:0] HDR_FIRST   = 8'd130;
   localparam logic [BYTE_W-1:0] HDR_LAST    = 8'd133;
   localparam logic [BYTE_W-1:0] HDR_BIAS    = 8'd129;
   localparam logic [PBS_W-1:0]  PBS_MAX     = 3'd7;
   localparam logic [VALUE_W-1:0] ALL_ONES   = 32'hffff_ffff;

   typedef enum logic [2:0] {
      PH_PREFIX = 3'b001,
      PH_EXP    = 3'b010,
      PH_DIGITS = 3'b100
   } phase_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [INDEX_W-1:0] digit_index;
      logic [VALUE_W-1:0] value;
      logic               last;
   } result_type;

endpackage

// File: hw/rtl/thd_in_stage.sv
// input register of the decoder
module thd_in_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [thd_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic                        take,
   output logic                        req_stall,
   output logic                        item_valid,
   output logic [thd_pkg::BYTE_W-1:0]  item_byte
);
   import thd_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;

   assign req_stall = valid_ff && !take;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (!req_stall) begin
         valid_in = req_valid;
         if (req_valid) begin
            byte_in = req_data_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

// File: hw/rtl/thd_parse.sv
// per-byte humber parser: tumbler state and result decode
module thd_parse (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [thd_pkg::BYTE_W-1:0]  item_byte,
   output logic                        has_result,
   output thd_pkg::result_type         result
);
   import thd_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [HBL_W-1:0]   hbl_ff, hbl_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [VALUE_W-1:0] tbl_ff, tbl_in;
   logic [PBS_W-1:0]   pbs_ff, pbs_in;
   logic [DC_W-1:0]    dc_ff, dc_in;

   always_comb begin
      logic               in_body;
      logic               fail;
      logic               have_val;
      logic [VALUE_W-1:0] val;
      logic [VALUE_W-1:0] tbl_dec;
      logic [VALUE_W-1:0] acc_sh;
      logic [PBS_W-1:0]   pbs_inc;
      logic [HBL_W-1:0]   hbl_dec;
      logic               at_end;

      phase_in   = phase_ff;
      hbl_in     = hbl_ff;
      acc_in     = acc_ff;
      tbl_in     = tbl_ff;
      pbs_in     = pbs_ff;
      dc_in      = dc_ff;
      has_result = 1'b0;
      result     = '0;
      fail       = 1'b0;
      have_val   = 1'b0;
      val        = '0;

      in_body = (phase_ff == PH_EXP) || (phase_ff == PH_DIGITS);
      tbl_dec = tbl_ff - VALUE_W'(1);
      pbs_inc = (pbs_ff < PBS_MAX) ? pbs_ff + PBS_W'(1) : pbs_ff;
      acc_sh  = {acc_ff[VALUE_W-BYTE_W-1:0], item_byte};
      hbl_dec = hbl_ff - HBL_W'(1);
      at_end  = (tbl_dec == '0);

      if (in_body && tbl_ff == '0) begin
         fail = 1'b1;
      end else begin
         if (in_body) begin
            tbl_in = tbl_dec;
         end else begin
            pbs_in = pbs_inc;
         end

         if (hbl_ff == '0) begin
            if (item_byte < SHORT_LIMIT) begin
               val      = VALUE_W'(item_byte);
               have_val = 1'b1;
            end else if (item_byte >= HDR_FIRST && item_byte <= HDR_LAST) begin
               hbl_in = HBL_W'(item_byte - HDR_BIAS);
               acc_in = '0;
               if (in_body && VALUE_W'(hbl_in) > tbl_dec) begin
                  fail = 1'b1;
               end
            end else begin
               fail = 1'b1;
            end
         end else begin
            hbl_in = hbl_dec;
            if (hbl_dec != '0) begin
               acc_in = acc_sh;
            end else begin
               val      = acc_sh;
               have_val = 1'b1;
            end
         end

         if (have_val) begin
            acc_in = '0;
            if (val == ALL_ONES) begin
               fail = 1'b1;
            end else begin
               unique case (phase_ff)
                  PH_EXP: begin
                     has_result         = 1'b1;
                     result.kind        = KIND_EXP;
                     result.value       = val;
                     if (at_end) begin
                        result.last = 1'b1;
                        phase_in    = PH_PREFIX;
                        hbl_in      = '0;
                        tbl_in      = '0;
                        pbs_in      = '0;
                        dc_in       = '0;
                     end else begin
                        phase_in = PH_DIGITS;
                        dc_in    = '0;
                     end
                  end
                  PH_DIGITS: begin
                     has_result         = (dc_ff < DC_W'(MAX_DIGITS));
                     result.kind        = KIND_DIGIT;
                     result.digit_index = INDEX_W'(dc_ff);
                     result.value       = val;
                     result.last        = at_end || (dc_ff == DC_W'(MAX_DIGITS - 1));
                     if (dc_ff < DC_W'(MAX_DIGITS)) begin
                        dc_in = dc_ff + DC_W'(1);
                     end
                     if (at_end) begin
                        phase_in = PH_PREFIX;
                        hbl_in   = '0;
                        tbl_in   = '0;
                        pbs_in   = '0;
                        dc_in    = '0;
                     end
                  end
                  default: begin
                     if (val <= VALUE_W'(pbs_inc)) begin
                        fail = 1'b1;
                     end else begin
                        tbl_in   = val - VALUE_W'(pbs_inc);
                        pbs_in   = '0;
                        dc_in    = '0;
                        phase_in = PH_EXP;
                     end
                  end
               endcase
            end
         end
      end

      if (fail) begin
         phase_in   = PH_PREFIX;
         hbl_in     = '0;
         acc_in     = '0;
         tbl_in     = '0;
         pbs_in     = '0;
         dc_in      = '0;
         has_result = 1'b1;
         result     = '0;
         result.kind = KIND_ERROR;
         result.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PREFIX;
         hbl_ff   <= '0;
         acc_ff   <= '0;
         tbl_ff   <= '0;
         pbs_ff   <= '0;
         dc_ff    <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         hbl_ff   <= hbl_in;
         acc_ff   <= acc_in;
         tbl_ff   <= tbl_in;
         pbs_ff   <= pbs_in;
         dc_ff    <= dc_in;
      end
   end

endmodule

// File: hw/rtl/thd_out_stage.sv
// result register of the decoder
module thd_out_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  thd_pkg::result_type           result,
   input  logic                          rsp_stall,
   output logic                          free,
   output logic                          rsp_valid,
   output logic [thd_pkg::KIND_W-1:0]    rsp_kind,
   output logic [thd_pkg::INDEX_W-1:0]   rsp_digit_index,
   output logic [thd_pkg::VALUE_W-1:0]   rsp_value,
   output logic                          rsp_last
);
   import thd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;
   result_type res_in;

   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (free) begin
         valid_in = load;
         if (load) begin
            res_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = res_ff.kind;
   assign rsp_digit_index = res_ff.digit_index;
   assign rsp_value       = res_ff.value;
   assign rsp_last        = res_ff.last;

endmodule

// File: hw/rtl/tumbler_humber_decoder_core.sv
// top level of the tumbler humber decoder
// Takes one stream byte per cycle and gives at most one result per byte: the
// exponent magnitude, each mantissa digit with its index (digits past the
// sixteenth are parsed but not shown), or a format error after which parsing
// restarts at a length prefix. A byte is held in the input register, is parsed
// and lands in the result register. Throughput is one byte per cycle; a held result
// blocks only a byte that itself makes a result, and one byte can wait in
// the input register behind it.
module tumbler_humber_decoder_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [thd_pkg::BYTE_W-1:0]    req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [thd_pkg::KIND_W-1:0]    rsp_kind,
   output logic [thd_pkg::INDEX_W-1:0]   rsp_digit_index,
   output logic [thd_pkg::VALUE_W-1:0]   rsp_value,
   output logic                          rsp_last
);
   import thd_pkg::*;

   logic              item_valid;
   logic [BYTE_W-1:0] item_byte;
   logic              has_result;
   result_type        result;
   logic              out_free;
   logic              take;

   assign take = item_valid && (!has_result || out_free);

   thd_in_stage u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .take          (take),
      .req_stall     (req_stall),
      .item_valid    (item_valid),
      .item_byte     (item_byte)
   );

   thd_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .advance    (take),
      .item_byte  (item_byte),
      .has_result (has_result),
      .result     (result)
   );

   thd_out_stage u_out (
      .clock           (clock),
      .reset           (reset),
      .load            (take && has_result),
      .result          (result),
      .rsp_stall       (rsp_stall),
      .free            (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_digit_index (rsp_digit_index),
      .rsp_value       (rsp_value),
      .rsp_last        (rsp_last)
   );

endmodule

// File: hw/rtl/thd_checker.sv
// port-level assertions for the tumbler humber decoder
module thd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [thd_pkg::KIND_W-1:0]    rsp_kind,
   input logic [thd_pkg::INDEX_W-1:0]   rsp_digit_index,
   input logic [thd_pkg::VALUE_W-1:0]   rsp_value,
   input logic                          rsp_last
);
   import thd_pkg::*;

   // input side only backs up behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_kind) && $stable(rsp_value)
         && $stable(rsp_digit_index) && $stable(rsp_last)))
      else $error("held result changed");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_ERROR) |->
         (rsp_last && rsp_value == '0 && rsp_digit_index == '0))
      else $error("malformed error item");

   a_kind_exp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_DIGIT) |->
         (rsp_digit_index == '0 && (rsp_kind == KIND_EXP || rsp_kind == KIND_ERROR)))
      else $error("bad kind or index");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind tumbler_humber_decoder_core thd_checker u_thd_checker (.*);

// File: test/testbench.sv
// self-checking testbench of the tumbler humber decoder: directed and random byte streams
module testbench;
   import thd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 6;
   localparam logic [BYTE_W-1:0] RESYNC_BYTE = 8'hff;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [KIND_W-1:0]   rsp_kind;
   logic [INDEX_W-1:0]  rsp_digit_index;
   logic [VALUE_W-1:0]  rsp_value;
   logic                rsp_last;

   tumbler_humber_decoder_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_digit_index (rsp_digit_index),
      .rsp_value       (rsp_value),
      .rsp_last        (rsp_last)
   );

   // decoder state mirror
   phase_type           dec_phase = PH_PREFIX;
   logic [HBL_W-1:0]    owed_bytes = '0;
   logic [VALUE_W-1:0]  gathered = '0;
   logic [VALUE_W-1:0]  body_left = '0;
   logic [PBS_W-1:0]    prefix_seen = '0;
   logic [DC_W-1:0]     digits_done = '0;

   result_type          decoded_humbers[$];
   logic [BYTE_W-1:0]   pending_bytes[$];

   int sender_idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int fault_count = 0;
   int bytes_sent = 0;
   int tumblers_built = 0;
   int results_checked = 0;
   int errors_flagged = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t ns: timeout with %0d results outstanding", $time, decoded_humbers.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic void clear_decoder();
      dec_phase = PH_PREFIX;
      owed_bytes = '0;
      gathered = '0;
      body_left = '0;
      prefix_seen = '0;
      digits_done = '0;
   endfunction

   function automatic void note_result(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] idx,
                                       logic [VALUE_W-1:0] val, logic lst);
      result_type r;
      r.kind = kind;
      r.digit_index = idx;
      r.value = val;
      r.last = lst;
      decoded_humbers.push_back(r);
   endfunction

   function automatic void flag_format_error();
      clear_decoder();
      note_result(KIND_ERROR, '0, '0, 1'b1);
   endfunction

   function automatic void decode_byte(logic [BYTE_W-1:0] b);
      logic [VALUE_W-1:0] v;
      logic in_body;
      int idx;
      logic ends;
      logic lst;
      in_body = (dec_phase != PH_PREFIX);
      if (in_body) begin
         if (body_left == 0) begin
            flag_format_error();
            return;
         end
         body_left--;
      end else if (prefix_seen < PBS_MAX) begin
         prefix_seen++;
      end
      if (owed_bytes == 0) begin
         if (b < SHORT_LIMIT) begin
            v = {24'd0, b};
         end else if (b >= HDR_FIRST && b <= HDR_LAST) begin
            owed_bytes = HBL_W'(b - HDR_BIAS);
            gathered = '0;
            if (in_body && owed_bytes > body_left)
               flag_format_error();
            return;
         end else begin
            flag_format_error();
            return;
         end
      end else begin
         gathered = {gathered[VALUE_W-BYTE_W-1:0], b};
         owed_bytes--;
         if (owed_bytes != 0)
            return;
         v = gathered;
      end
      gathered = '0;
      if (v == ALL_ONES) begin
         flag_format_error();
         return;
      end
      case (dec_phase)
         PH_PREFIX: begin
            if (v <= prefix_seen) begin
               flag_format_error();
               return;
            end
            body_left = v - prefix_seen;
            prefix_seen = '0;
            digits_done = '0;
            dec_phase = PH_EXP;
         end
         PH_EXP: begin
            if (body_left == 0) begin
               clear_decoder();
               note_result(KIND_EXP, '0, v, 1'b1);
            end else begin
               dec_phase = PH_DIGITS;
               digits_done = '0;
               note_result(KIND_EXP, '0, v, 1'b0);
            end
         end
         default: begin
            idx = digits_done;
            ends = (body_left == 0);
            lst = ends || (idx + 1 == MAX_DIGITS);
            if (digits_done < MAX_DIGITS)
               digits_done++;
            if (ends)
               clear_decoder();
            if (idx < MAX_DIGITS)
               note_result(KIND_DIGIT, INDEX_W'(idx), v, lst);
         end
      endcase
   endfunction

   function automatic logic at_tumbler_start();
      return dec_phase == PH_PREFIX && owed_bytes == 0 && prefix_seen == 0;
   endfunction

   function automatic void check_field(string name, logic [VALUE_W-1:0] want,
                                       logic [VALUE_W-1:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fault_count++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_humbers.size() == 0) begin
            $display("%0t ns: unexpected item, expected none, actual kind %0d value %0h",
                     $time, rsp_kind, rsp_value);
            fault_count++;
         end else begin
            want = decoded_humbers.pop_front();
            check_field("kind", VALUE_W'(want.kind), VALUE_W'(rsp_kind));
            check_field("digit_index", VALUE_W'(want.digit_index), VALUE_W'(rsp_digit_index));
            check_field("value", want.value, rsp_value);
            check_field("last", VALUE_W'(want.last), VALUE_W'(rsp_last));
            results_checked++;
            if (want.kind == KIND_ERROR)
               errors_flagged++;
         end
      end
   end

   // receiver side: random stalls plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_byte(logic [BYTE_W-1:0] b);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      decode_byte(b);
      bytes_sent++;
   endtask

   task automatic send_pending();
      foreach (pending_bytes[i])
         send_byte(pending_bytes[i]);
      pending_bytes = {};
   endtask

   task automatic resync();
      while (!at_tumbler_start())
         send_byte(RESYNC_BYTE);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (decoded_humbers.size() == 0);
   endtask

   function automatic void put_humber_n(logic [VALUE_W-1:0] v, int n);
      if (n == 0) begin
         pending_bytes.push_back(v[BYTE_W-1:0]);
      end else begin
         pending_bytes.push_back(HDR_BIAS + BYTE_W'(n));
         for (int i = n - 1; i >= 0; i--)
            pending_bytes.push_back(BYTE_W'(v >> (8 * i)));
      end
   endfunction

   function automatic void put_humber(logic [VALUE_W-1:0] v, logic wide);
      int n;
      n = (v < 32'h100) ? 1 : (v < 32'h1_0000) ? 2 : (v < 32'h100_0000) ? 3 : 4;
      if (v < 32'd128 && !wide)
         n = 0;
      else if (wide)
         n = $urandom_range(n, 4);
      put_humber_n(v, n);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] v;
      case ($urandom_range(0, 5))
         0: v = $urandom_range(0, 127);
         1: v = $urandom_range(128, 65535);
         2: v = $urandom_range(32'h1_0000, 32'hffff_fffe);
         3: v = ALL_ONES - 1;
         4: v = '0;
         default: begin
            v = $urandom;
            if (v == ALL_ONES)
               v = '0;
         end
      endcase
      return v;
   endfunction

   function automatic int pick_digit_count();
      int r;
      r = $urandom_range(99);
      if (r < 78)
         return $urandom_range(0, 5);
      else if (r < 91)
         return $urandom_range(6, 16);
      return $urandom_range(17, 20);
   endfunction

   // fills pending_bytes with one tumbler; ones_digit < 0 means every digit is legal
   function automatic void build_tumbler(int n_digits, int len_adjust, int wide_pct,
                                         int ones_digit);
      logic [BYTE_W-1:0] body[$];
      int n;
      int total;
      pending_bytes = {};
      put_humber(pick_value(), $urandom_range(99) < wide_pct);
      for (int i = 0; i < n_digits; i++) begin
         if (i == ones_digit)
            put_humber_n(ALL_ONES, 4);
         else
            put_humber(pick_value(), $urandom_range(99) < wide_pct);
      end
      body = pending_bytes;
      pending_bytes = {};
      n = ($urandom_range(99) < wide_pct) ? $urandom_range(1, 4) : 0;
      total = body.size() + 1 + n + len_adjust;
      if (total < 0)
         total = 0;
      put_humber_n(total, n);
      pending_bytes = {pending_bytes, body};
      tumblers_built++;
   endfunction

   task automatic send_broken_tumbler();
      int k;
      int adj;
      logic [BYTE_W-1:0] bad;
      case ($urandom_range(0, 4))
         0: begin
            build_tumbler(pick_digit_count(), 0, 25, -1);
            pending_bytes = pending_bytes[0:$urandom_range(0, pending_bytes.size() - 2)];
         end
         1: begin
            build_tumbler(pick_digit_count(), 0, 25, -1);
            k = $urandom_range(0, pending_bytes.size() - 1);
            pending_bytes[k] = BYTE_W'($urandom_range(0, 255));
         end
         2: begin
            adj = $urandom_range(0, 5) - 3;
            if (adj >= 0)
               adj++;
            build_tumbler(pick_digit_count(), adj, 25, -1);
         end
         3: begin
            k = pick_digit_count() + 1;
            build_tumbler(k, 0, 25, $urandom_range(0, k - 1));
         end
         default: begin
            build_tumbler(pick_digit_count(), 0, 25, -1);
            case ($urandom_range(0, 2))
               0: bad = SHORT_LIMIT;
               1: bad = SHORT_LIMIT + 8'd1;
               default: bad = BYTE_W'($urandom_range(HDR_LAST + 1, 255));
            endcase
            k = $urandom_range(0, pending_bytes.size() - 1);
            pending_bytes.insert(k, bad);
         end
      endcase
      send_pending();
      resync();
   endtask

   task automatic test_directed();
      // smallest tumbler, exponent only
      pending_bytes = {8'd2, 8'd0};
      // largest short exponent and one digit
      pending_bytes = {pending_bytes, 8'd3, 8'd127, 8'd0};
      // four-byte digit
      pending_bytes = {pending_bytes, 8'd7, 8'd0, HDR_LAST, 8'h12, 8'h34, 8'h56, 8'h78};
      // bad headers at the prefix
      pending_bytes = {pending_bytes, SHORT_LIMIT, SHORT_LIMIT + 8'd1, HDR_LAST + 8'd1, 8'hff};
      // length prefix too small
      pending_bytes = {pending_bytes, 8'd0, 8'd1};
      // all-ones value
      pending_bytes = {pending_bytes, HDR_LAST, 8'hff, 8'hff, 8'hff, 8'hff};
      // humber crossing the declared end
      pending_bytes = {pending_bytes, 8'd4, 8'd0, HDR_LAST};
      send_pending();
   endtask

   task automatic test_mixed_stream(int idle_pct, int stall_chance, int n_bytes);
      int stop_at;
      int r;
      sender_idle_pct = idle_pct;
      stall_pct = stall_chance;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) begin
         r = $urandom_range(99);
         if (r < 80) begin
            build_tumbler(pick_digit_count(), 0, 25, -1);
            send_pending();
         end else if (r < 92) begin
            send_broken_tumbler();
         end else begin
            repeat ($urandom_range(1, 8))
               send_byte(BYTE_W'($urandom_range(0, 255)));
            resync();
         end
      end
   endtask

   task automatic test_receiver_hold_off();
      sender_idle_pct = 0;
      stall_pct = 0;
      hold_requests++;
      repeat (4) begin
         build_tumbler(12, 0, 0, -1);
         send_pending();
      end
   endtask

   task automatic test_sender_pause();
      sender_idle_pct = 18;
      stall_pct = 18;
      repeat (5) begin
         build_tumbler(pick_digit_count(), 0, 40, -1);
         send_pending();
         wait_for_results();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_mixed_stream(0, 0, 120);
      test_mixed_stream(63, 0, 120);
      test_mixed_stream(0, 63, 120);
      test_mixed_stream(18, 18, 120);
      test_receiver_hold_off();
      test_sender_pause();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d stream bytes, %0d tumblers built, %0d results checked (%0d errors)",
               bytes_sent, tumblers_built, results_checked, errors_flagged);
      $display("idling phases: none, sender, receiver, both; one long receiver hold-off");
      if (fault_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/thd_pkg.sv
hw/rtl/thd_in_stage.sv
hw/rtl/thd_parse.sv
hw/rtl/thd_out_stage.sv
hw/rtl/tumbler_humber_decoder_core.sv
hw/rtl/thd_checker.sv
test/testbench.sv
